@@ hw/rtl/rolling_hash_pattern_matcher_macros.svh @@
// Assertion macros for the rolling hash pattern matcher.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef ROLLING_HASH_PATTERN_MATCHER_MACROS_SVH
`define ROLLING_HASH_PATTERN_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define RHPM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RHPM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rhpm_pkg.sv @@
// Shared types, constants and helpers for the rolling hash pattern matcher.
// No dependencies; used by rhpm_cell and rolling_hash_pattern_matcher.
package rhpm_pkg;

    localparam int HASH_W      = 40;   // exact signed hash width
    localparam int TERM_W      = 9;    // signed (code - bias)
    localparam int WEIGHT_W    = 32;   // pattern weight register width
    localparam int FIELD_W     = 20;   // result field width
    localparam int CHAR_BIAS   = 64;
    localparam int PATTERN_LIM = 20;   // largest supported pattern length

    typedef logic signed [HASH_W-1:0] t_hash;
    typedef logic signed [TERM_W-1:0] t_term;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_PATTERN = 2'd1,
        OP_TEXT    = 2'd2,
        OP_RESTART = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic               match;
        logic [FIELD_W-1:0] start_position;
        logic [FIELD_W-1:0] end_position;
        logic [FIELD_W-1:0] match_count;
        logic               pattern_overflow;
    } t_out_item;

    localparam logic [FIELD_W-1:0] COUNT_MAX = {FIELD_W{1'b1}};

    // Character byte to its signed term
    function automatic t_term to_term(input logic [7:0] c);
        return t_term'({1'b0, c}) - t_term'(CHAR_BIAS);
    endfunction

    // 3^n, for elaboration-time weights only
    function automatic t_hash pow3(input int n);
        t_hash w;
        w = t_hash'(1);
        for (int i = 0; i < PATTERN_LIM; i++) begin
            if (i < n) begin
                w = w * t_hash'(3);
            end
        end
        return w;
    endfunction

endpackage

@@ hw/rtl/rhpm_cell.sv @@
// One cell of the matching chain: candidate window at a fixed character offset.
// Depends on rhpm_pkg.
module rhpm_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_shift,
    input  rhpm_pkg::t_term i_term,
    input  rhpm_pkg::t_hash i_acc_prev,
    input  rhpm_pkg::t_hash i_pattern_hash,
    output rhpm_pkg::t_hash o_acc,
    output logic           o_eq
);
    import rhpm_pkg::*;

    // weight of the character at this offset within the window
    localparam t_hash WEIGHT = pow3(STAGE);

    t_hash w_prod;
    t_hash n_acc;
    t_hash r_acc;

    // constant multiply and accumulate onto the neighbour's partial hash
    always_comb begin
        w_prod = t_hash'(i_term) * WEIGHT;
        n_acc  = i_acc_prev + w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_acc <= n_acc;
        end
    end

    // only the cell at the pattern length is looked at by the top level
    assign o_eq  = (n_acc == i_pattern_hash);
    assign o_acc = r_acc;

endmodule

@@ hw/rtl/rolling_hash_pattern_matcher.sv @@
// Rolling hash pattern matcher: pattern/text characters in, one result item per input item.
// Depends on rhpm_pkg, rhpm_cell and rolling_hash_pattern_matcher_macros.svh.
//
// Takes one item per clock while the output is not stalled and gives its result in the
// next cycle through an output register; a new item is taken in the same cycle the
// waiting result is taken. Each text character advances a chain of MAX_PATTERN cells,
// cell k holding the hash of the candidate window that has seen k+1 characters; all
// cells update in the one cycle (a constant multiply, an add and a compare each), which
// sets the one-item-per-cycle rate. A match is hash equality only. Pattern characters
// (while the pattern is not full) and the restart opcode clear the text scan; clear
// also drops the pattern. There is no clearing pass after reset.
`include "rolling_hash_pattern_matcher_macros.svh"

module rolling_hash_pattern_matcher #(
    parameter int MAX_PATTERN   = 16,
    parameter int POSITION_BITS = 20
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rhpm_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rhpm_pkg::t_out_item o_out_data
);
    import rhpm_pkg::*;

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(MAX_PATTERN);

    // pattern state
    t_hash                  r_pat_hash,   n_pat_hash;
    logic [LEN_W-1:0]       r_pat_len,    n_pat_len;
    logic [WEIGHT_W-1:0]    r_pat_weight, n_pat_weight;
    // text scan state
    logic [POSITION_BITS-1:0] r_text_pos, n_text_pos;
    logic [FIELD_W-1:0]       r_found,    n_found;
    // output register
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic  w_accept;
    logic  w_shift;
    t_term w_term;

    t_hash                  w_acc [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] w_eq;
    logic [MAX_PATTERN-1:0] w_tap;

    logic signed [TERM_W+WEIGHT_W:0] w_pat_prod;
    logic [POSITION_BITS-1:0]        w_pos_next;
    logic                            w_window_full;
    logic                            w_hit;
    logic [POSITION_BITS-1:0]        w_start;
    logic [POSITION_BITS:0]          w_end_wide;
    logic [POSITION_BITS-1:0]        w_end;
    logic [FIELD_W+POSITION_BITS-1:0] w_start_ext;
    logic [FIELD_W+POSITION_BITS-1:0] w_end_ext;

    // handshake: the output register parts the two sides
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_shift     = w_accept && (i_in_data.opcode == OP_TEXT);
    assign w_term      = to_term(i_in_data.char_code);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // chain of cells, each handing its partial hash to the next
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        t_hash w_prev;
        if (k == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_rest
            assign w_prev = w_acc[k-1];
        end
        rhpm_cell #(
            .STAGE (k)
        ) u_cell (
            .i_clk          (i_clk),
            .i_shift        (w_shift),
            .i_term         (w_term),
            .i_acc_prev     (w_prev),
            .i_pattern_hash (r_pat_hash),
            .o_acc          (w_acc[k]),
            .o_eq           (w_eq[k])
        );
        assign w_tap[k] = (r_pat_len == LEN_W'(k + 1));
    end

    // match detection and position arithmetic for a text item
    always_comb begin
        w_pat_prod    = w_term * $signed({1'b0, r_pat_weight});
        w_pos_next    = (r_text_pos == POS_MAX) ? r_text_pos
                                                : r_text_pos + POSITION_BITS'(1);
        w_window_full = ({1'b0, r_text_pos} + (POSITION_BITS+1)'(1))
                        >= (POSITION_BITS+1)'(r_pat_len);
        w_hit         = (r_pat_len != '0) && w_window_full && (|(w_eq & w_tap));
        w_start       = w_pos_next - POSITION_BITS'(r_pat_len) + POSITION_BITS'(1);
        w_end_wide    = {1'b0, w_start} + (POSITION_BITS+1)'(r_pat_len);
        w_end         = (w_end_wide > {1'b0, POS_MAX}) ? POS_MAX
                                                       : w_end_wide[POSITION_BITS-1:0];
        w_start_ext   = {{FIELD_W{1'b0}}, w_start};
        w_end_ext     = {{FIELD_W{1'b0}}, w_end};
    end

    // opcode decode: next state and result item
    always_comb begin
        n_pat_hash   = r_pat_hash;
        n_pat_len    = r_pat_len;
        n_pat_weight = r_pat_weight;
        n_text_pos   = r_text_pos;
        n_found      = r_found;
        n_out        = '0;
        unique case (i_in_data.opcode)
            OP_CLEAR: begin
                n_pat_hash   = '0;
                n_pat_len    = '0;
                n_pat_weight = WEIGHT_W'(1);
                n_text_pos   = '0;
                n_found      = '0;
            end
            OP_PATTERN: begin
                if (r_pat_len == LEN_FULL) begin
                    n_out.pattern_overflow = 1'b1;
                    n_out.match_count      = r_found;
                end else begin
                    n_pat_hash   = r_pat_hash + HASH_W'(w_pat_prod);
                    n_pat_len    = r_pat_len + LEN_W'(1);
                    n_pat_weight = (r_pat_weight << 1) + r_pat_weight;
                    n_text_pos   = '0;
                    n_found      = '0;
                end
            end
            OP_TEXT: begin
                n_text_pos = w_pos_next;
                if (w_hit && (r_found != COUNT_MAX)) begin
                    n_found = r_found + FIELD_W'(1);
                end
                n_out.match_count = n_found;
                if (w_hit) begin
                    n_out.match          = 1'b1;
                    n_out.start_position = w_start_ext[FIELD_W-1:0];
                    n_out.end_position   = w_end_ext[FIELD_W-1:0];
                end
            end
            OP_RESTART: begin
                n_text_pos = '0;
                n_found    = '0;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_hash   <= '0;
            r_pat_len    <= '0;
            r_pat_weight <= WEIGHT_W'(1);
            r_text_pos   <= '0;
            r_found      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_pat_hash   <= n_pat_hash;
                r_pat_len    <= n_pat_len;
                r_pat_weight <= n_pat_weight;
                r_text_pos   <= n_text_pos;
                r_found      <= n_found;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    // checks
    `RHPM_ASSERT_NOW(a_match_needs_pattern, o_out_valid && o_out_data.match, r_pat_len != '0, "match reported with empty pattern")
    `RHPM_ASSERT_NOW(a_match_counted, o_out_valid && o_out_data.match, o_out_data.match_count != '0, "match reported with zero count")
    `RHPM_ASSERT_NOW(a_overflow_only_full, o_out_valid && o_out_data.pattern_overflow, (r_pat_len == LEN_FULL) && !o_out_data.match, "pattern overflow flagged while pattern not full")
    `RHPM_ASSERT_NEXT(a_clear_resets, w_accept && (i_in_data.opcode == OP_CLEAR), (r_pat_len == '0) && (r_found == '0) && (r_text_pos == '0), "clear left state behind")
    `RHPM_ASSERT_NOW(a_stall_blocks_input, o_out_valid && !i_out_ready, !o_in_ready, "item taken while result stalled")

endmodule
